[hdl/dtp_pkg.sv]
package dtp_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned ADC_W      = 10;
  localparam int unsigned KEY_W      = 4;
  localparam int unsigned SETPOINT_W = 10;
  localparam int unsigned DEADBAND_W = 7;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned PAGE_W     = 2;

  localparam int unsigned TEMP_W = 19;
  localparam int unsigned BAND_W = 17;

  localparam int unsigned ADC_SCALE    = 489;
  localparam int unsigned TENTHS_SCALE = 100;

  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 7'd5;
  localparam logic [SETPOINT_W-1:0] MIN_SP_RESET   = 10'd120;
  localparam logic [SETPOINT_W-1:0] MAX_SP_RESET   = 10'd350;
  localparam logic [DUTY_W-1:0]     DUTY_RESET     = 8'd200;
  localparam logic [SETPOINT_W-1:0] SETPOINT_RESET = 10'd220;

  localparam logic [KEY_W-1:0] KEY_UP    = 4'd2;
  localparam logic [KEY_W-1:0] KEY_LEFT  = 4'd4;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 4'd6;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 4'd8;

  localparam logic [PAGE_W-1:0] PAGE_BLANK    = 2'd0;
  localparam logic [PAGE_W-1:0] PAGE_FIRST    = 2'd1;
  localparam logic [PAGE_W-1:0] PAGE_SETPOINT = 2'd3;

  localparam logic [1:0] REG_DEADBAND = 2'd0;
  localparam logic [1:0] REG_MIN_SP   = 2'd1;
  localparam logic [1:0] REG_MAX_SP   = 2'd2;
  localparam logic [1:0] REG_DUTY     = 2'd3;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_KEY    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e_t;

  typedef struct packed {
    logic [DEADBAND_W-1:0] deadband_tenths;
    logic [SETPOINT_W-1:0] min_setpoint_tenths;
    logic [SETPOINT_W-1:0] max_setpoint_tenths;
    logic [DUTY_W-1:0]     drive_duty;
  } cfg_t;

  typedef struct packed {
    logic                  heater_on;
    logic                  cooler_on;
    logic [PAGE_W-1:0]     display_index;
    logic [SETPOINT_W-1:0] setpoint_out;
  } result_t;

endpackage

[hdl/dtp_cfg.sv]
module dtp_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dtp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [dtp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [dtp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output dtp_pkg::cfg_t                   cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadband_tenths     <= dtp_pkg::DEADBAND_RESET;
      cfg.min_setpoint_tenths <= dtp_pkg::MIN_SP_RESET;
      cfg.max_setpoint_tenths <= dtp_pkg::MAX_SP_RESET;
      cfg.drive_duty          <= dtp_pkg::DUTY_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        dtp_pkg::REG_DEADBAND: begin
          cfg.deadband_tenths <= pwdata[dtp_pkg::DEADBAND_W-1:0];
        end
        dtp_pkg::REG_MIN_SP: begin
          cfg.min_setpoint_tenths <= pwdata[dtp_pkg::SETPOINT_W-1:0];
        end
        dtp_pkg::REG_MAX_SP: begin
          cfg.max_setpoint_tenths <= pwdata[dtp_pkg::SETPOINT_W-1:0];
        end
        dtp_pkg::REG_DUTY: begin
          cfg.drive_duty <= pwdata[dtp_pkg::DUTY_W-1:0];
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_index)
      dtp_pkg::REG_DEADBAND: begin
        prdata[dtp_pkg::DEADBAND_W-1:0] = cfg.deadband_tenths;
      end
      dtp_pkg::REG_MIN_SP: begin
        prdata[dtp_pkg::SETPOINT_W-1:0] = cfg.min_setpoint_tenths;
      end
      dtp_pkg::REG_MAX_SP: begin
        prdata[dtp_pkg::SETPOINT_W-1:0] = cfg.max_setpoint_tenths;
      end
      dtp_pkg::REG_DUTY: begin
        prdata[dtp_pkg::DUTY_W-1:0] = cfg.drive_duty;
      end
    endcase
  end

endmodule

[hdl/dtp_core.sv]
module dtp_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  dtp_pkg::cmd_e_t                cmd,
  input  logic [dtp_pkg::ADC_W-1:0]      adc_sample,
  input  logic [dtp_pkg::KEY_W-1:0]      key_value,
  input  dtp_pkg::cfg_t                  cfg,
  output dtp_pkg::result_t               result
);

  logic [dtp_pkg::SETPOINT_W-1:0] setpoint;
  logic [dtp_pkg::SETPOINT_W-1:0] setpoint_next;
  logic                           heat_demand;
  logic                           heat_demand_next;
  logic                           cool_demand;
  logic                           cool_demand_next;
  logic [dtp_pkg::DUTY_W-1:0]     pwm_count;
  logic [dtp_pkg::DUTY_W-1:0]     pwm_count_next;
  logic [dtp_pkg::PAGE_W-1:0]     page;
  logic [dtp_pkg::PAGE_W-1:0]     page_next;

  logic [dtp_pkg::TEMP_W-1:0]       temp;
  logic                             lo_valid;
  logic [dtp_pkg::SETPOINT_W-1:0]   lo_diff;
  logic [dtp_pkg::SETPOINT_W:0]     hi_sum;
  logic [dtp_pkg::BAND_W-1:0]       lo_band;
  logic [dtp_pkg::BAND_W-1:0]       hi_band;
  logic                             heat_sample;
  logic                             cool_sample;

  logic [dtp_pkg::PAGE_W-1:0]       page_key;
  logic                             on_sp_page;
  logic signed [11:0]               sp_step;
  logic signed [11:0]               sp_upper;
  logic signed [11:0]               sp_lower;
  logic signed [11:0]               max_s;
  logic signed [11:0]               min_s;

  assign temp     = {9'd0, adc_sample} * dtp_pkg::TEMP_W'(dtp_pkg::ADC_SCALE);
  assign lo_valid = setpoint >= {3'd0, cfg.deadband_tenths};
  assign lo_diff  = setpoint - {3'd0, cfg.deadband_tenths};
  assign hi_sum   = {1'b0, setpoint} + {4'd0, cfg.deadband_tenths};
  assign lo_band  = {7'd0, lo_diff} * dtp_pkg::BAND_W'(dtp_pkg::TENTHS_SCALE);
  assign hi_band  = {6'd0, hi_sum} * dtp_pkg::BAND_W'(dtp_pkg::TENTHS_SCALE);

  assign heat_sample = lo_valid && (temp < {2'd0, lo_band});
  assign cool_sample = !heat_sample && (temp > {2'd0, hi_band});

  assign on_sp_page = page == dtp_pkg::PAGE_SETPOINT;
  assign max_s      = $signed({2'd0, cfg.max_setpoint_tenths});
  assign min_s      = $signed({2'd0, cfg.min_setpoint_tenths});

  always_comb begin
    priority if (key_value == dtp_pkg::KEY_RIGHT) begin
      page_key = (page == dtp_pkg::PAGE_SETPOINT) ? dtp_pkg::PAGE_FIRST : page + 2'd1;
    end else if (key_value == dtp_pkg::KEY_LEFT) begin
      page_key = (page <= dtp_pkg::PAGE_FIRST) ? dtp_pkg::PAGE_SETPOINT : page - 2'd1;
    end else begin
      page_key = (page == dtp_pkg::PAGE_BLANK) ? dtp_pkg::PAGE_SETPOINT : page;
    end

    sp_step = $signed({2'd0, setpoint});
    if (on_sp_page && key_value == dtp_pkg::KEY_UP) begin
      sp_step = sp_step + 12'sd1;
    end else if (on_sp_page && key_value == dtp_pkg::KEY_DOWN) begin
      sp_step = sp_step - 12'sd1;
    end

    sp_upper = (sp_step > max_s) ? max_s : sp_step;
    sp_lower = (sp_upper < min_s) ? min_s : sp_upper;
  end

  always_comb begin
    setpoint_next    = setpoint;
    heat_demand_next = heat_demand;
    cool_demand_next = cool_demand;
    pwm_count_next   = pwm_count;
    page_next        = page;
    unique case (cmd)
      dtp_pkg::CMD_TICK: begin
        pwm_count_next = pwm_count + 8'd1;
      end
      dtp_pkg::CMD_SAMPLE: begin
        heat_demand_next = heat_sample;
        cool_demand_next = cool_sample;
      end
      dtp_pkg::CMD_KEY: begin
        page_next     = page_key;
        setpoint_next = sp_lower[dtp_pkg::SETPOINT_W-1:0];
      end
      dtp_pkg::CMD_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint    <= dtp_pkg::SETPOINT_RESET;
      heat_demand <= 1'b0;
      cool_demand <= 1'b0;
      pwm_count   <= '0;
      page        <= dtp_pkg::PAGE_BLANK;
    end else if (adv) begin
      setpoint    <= setpoint_next;
      heat_demand <= heat_demand_next;
      cool_demand <= cool_demand_next;
      pwm_count   <= pwm_count_next;
      page        <= page_next;
    end
  end

  always_comb begin
    result.heater_on     = heat_demand_next && (pwm_count_next < cfg.drive_duty);
    result.cooler_on     = cool_demand_next && (pwm_count_next < cfg.drive_duty);
    result.display_index = page_next;
    result.setpoint_out  = setpoint_next;
  end

  a_demand_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(heat_demand && cool_demand))
    else $error("heat and cool demand both set");

  a_key_leaves_blank: assert property (@(posedge clk) disable iff (rst)
    (adv && cmd == dtp_pkg::CMD_KEY) |=> (page != dtp_pkg::PAGE_BLANK))
    else $error("page left at blank after a key");

  a_setpoint_clamped: assert property (@(posedge clk) disable iff (rst)
    (adv && cmd == dtp_pkg::CMD_KEY
      && cfg.min_setpoint_tenths <= cfg.max_setpoint_tenths)
    |=> (setpoint <= $past(cfg.max_setpoint_tenths)
      && setpoint >= $past(cfg.min_setpoint_tenths)))
    else $error("setpoint outside its limits after a key");

endmodule

[hdl/deadband_thermostat_pwm.sv]
// Thermostat with a deadband and PWM drive. Each item is a timer tick, a temperature sample
// or a key press, and it produces exactly one result item with the heater and cooler levels,
// the menu page and the setpoint, all taken after the item is applied. The block accepts
// one item per clock cycle while m_tready is high; an accepted item waits in the input
// register until the result register is free, and its result then passes the single
// update stage into the result register. The result register lets a new item enter while
// a finished result waits to be taken.
// Registers on the APB port sit at byte offsets 0 (deadband), 4 (minimum setpoint),
// 8 (maximum setpoint) and 12 (drive duty); write them only while no item is in flight.
module deadband_thermostat_pwm (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [15:0]                     s_tdata,   // adc_sample[9:0], key_value[13:10]
  input  logic [1:0]                      s_tuser,   // cmd[1:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,   // heater_on, cooler_on,
                                                     // display_index[3:2], setpoint_out[13:4]
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dtp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [dtp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [dtp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  dtp_pkg::cfg_t                  cfg;
  dtp_pkg::result_t               result;
  dtp_pkg::result_t               out_result;

  logic                           in_valid;
  dtp_pkg::cmd_e_t                in_cmd;
  logic [dtp_pkg::ADC_W-1:0]      in_adc;
  logic [dtp_pkg::KEY_W-1:0]      in_key;
  logic                           advance;
  logic                           take;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign take     = s_tvalid && s_tready;

  dtp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dtp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .adv        (advance),
    .cmd        (in_cmd),
    .adc_sample (in_adc),
    .key_value  (in_key),
    .cfg        (cfg),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_cmd <= dtp_pkg::cmd_e_t'(s_tuser);
      in_adc <= s_tdata[9:0];
      in_key <= s_tdata[13:10];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tdata = {2'd0, out_result.setpoint_out, out_result.display_index,
                    out_result.cooler_on, out_result.heater_on};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with an empty result register");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("result register not loaded after an item advanced");

  a_held_item_stays: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_cmd)))
    else $error("held item lost from the input register");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import dtp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 65;
  localparam int unsigned PHASE_COUNT = 8;
  localparam logic [KEY_W-1:0] KEY_STAR = 4'd10;
  localparam logic [KEY_W-1:0] KEY_HASH = 4'd11;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;  // adc_sample[9:0], key_value[13:10]
  logic [1:0] s_tuser = '0;   // cmd[1:0]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;       // heater_on, cooler_on, display_index[3:2], setpoint_out[13:4]
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  deadband_thermostat_pwm dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Thermostat state as the block should hold it.
  logic [DEADBAND_W-1:0] band_cfg = DEADBAND_RESET;
  logic [SETPOINT_W-1:0] sp_floor = MIN_SP_RESET;
  logic [SETPOINT_W-1:0] sp_ceiling = MAX_SP_RESET;
  logic [DUTY_W-1:0] duty_cfg = DUTY_RESET;
  logic [SETPOINT_W-1:0] sp_tenths = SETPOINT_RESET;
  logic heat_want = 1'b0;
  logic cool_want = 1'b0;
  logic [DUTY_W-1:0] pwm_phase = '0;
  logic [PAGE_W-1:0] menu_page = PAGE_BLANK;

  result_t expected_results[$];
  int err_count = 0;
  int burst_left = 0;
  int unsigned cycle_count = 0;
  logic [9:0] stall_cycle = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    case (stall_cycle[9:8])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= ($urandom_range(0, 1) == 0);
      2'd2: m_tready <= (stall_cycle[1:0] == 2'd0);
      default: m_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected, tdata %h", m_tdata);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[0] !== want.heater_on) begin
          $error("heater_on: expected %0d, got %0d", want.heater_on, m_tdata[0]);
          err_count++;
        end
        if (m_tdata[1] !== want.cooler_on) begin
          $error("cooler_on: expected %0d, got %0d", want.cooler_on, m_tdata[1]);
          err_count++;
        end
        if (m_tdata[3:2] !== want.display_index) begin
          $error("display_index: expected %0d, got %0d", want.display_index, m_tdata[3:2]);
          err_count++;
        end
        if (m_tdata[13:4] !== want.setpoint_out) begin
          $error("setpoint_out: expected %0d, got %0d", want.setpoint_out, m_tdata[13:4]);
          err_count++;
        end
      end
    end
  end

  task automatic update_thermostat(cmd_e_t cmd, logic [ADC_W-1:0] adc, logic [KEY_W-1:0] key);
    int temp;
    int lo_band;
    int hi_band;
    int sp;
    int pg;
    result_t r;
    case (cmd)
      CMD_TICK: pwm_phase = pwm_phase + 8'd1;
      CMD_SAMPLE: begin
        temp = int'(adc) * int'(ADC_SCALE);
        lo_band = (int'(sp_tenths) - int'(band_cfg)) * int'(TENTHS_SCALE);
        hi_band = (int'(sp_tenths) + int'(band_cfg)) * int'(TENTHS_SCALE);
        heat_want = temp < lo_band;
        cool_want = !heat_want && (temp > hi_band);
      end
      CMD_KEY: begin
        sp = int'(sp_tenths);
        pg = int'(menu_page);
        if (key == KEY_RIGHT) begin
          pg = pg + 1;
        end else if (key == KEY_LEFT) begin
          pg = (pg == int'(PAGE_BLANK)) ? int'(PAGE_SETPOINT) : pg - 1;
        end else if (key == KEY_UP && pg == int'(PAGE_SETPOINT)) begin
          sp = sp + 1;
        end else if (key == KEY_DOWN && pg == int'(PAGE_SETPOINT)) begin
          sp = sp - 1;
        end
        if (pg > int'(PAGE_SETPOINT)) pg = int'(PAGE_FIRST);
        if (pg == int'(PAGE_BLANK)) pg = int'(PAGE_SETPOINT);
        if (sp > int'(sp_ceiling)) sp = int'(sp_ceiling);
        if (sp < int'(sp_floor)) sp = int'(sp_floor);
        menu_page = pg[PAGE_W-1:0];
        sp_tenths = sp[SETPOINT_W-1:0];
      end
      default: ;
    endcase
    r.heater_on = heat_want && (pwm_phase < duty_cfg);
    r.cooler_on = cool_want && (pwm_phase < duty_cfg);
    r.display_index = menu_page;
    r.setpoint_out = sp_tenths;
    expected_results.push_back(r);
  endtask

  task automatic send_item(cmd_e_t cmd, logic [ADC_W-1:0] adc, logic [KEY_W-1:0] key);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {2'b00, key, adc};
    do @(posedge clk); while (!s_tready);
    update_thermostat(cmd, adc, key);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_DEADBAND: band_cfg = value[DEADBAND_W-1:0];
      REG_MIN_SP: sp_floor = value[SETPOINT_W-1:0];
      REG_MAX_SP: sp_ceiling = value[SETPOINT_W-1:0];
      default: duty_cfg = value[DUTY_W-1:0];
    endcase
  endtask

  task automatic cfg_read(logic [1:0] idx, logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("register %0d readback: expected %0d, got %0d", idx, want, prdata);
      err_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_registers();
    wait_idle();
    cfg_read(REG_DEADBAND, 32'(band_cfg));
    cfg_read(REG_MIN_SP, 32'(sp_floor));
    cfg_read(REG_MAX_SP, 32'(sp_ceiling));
    cfg_read(REG_DUTY, 32'(duty_cfg));
  endtask

  // A key press clamps the setpoint, so equal limits pin it to any value.
  task automatic pin_setpoint(int target);
    cfg_write(REG_MIN_SP, target);
    cfg_write(REG_MAX_SP, target);
    send_item(CMD_KEY, '0, KEY_HASH);
  endtask

  task automatic set_config(int band, int floor_sp, int ceiling_sp, int duty);
    cfg_write(REG_DEADBAND, band);
    cfg_write(REG_MIN_SP, floor_sp);
    cfg_write(REG_MAX_SP, ceiling_sp);
    cfg_write(REG_DUTY, duty);
  endtask

  task automatic test_reset_state();
    check_registers();
    send_item(CMD_NONE, 10'h3FF, 4'hF);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_SAMPLE, '0, '0);
  endtask

  task automatic test_menu_pages();
    case ($urandom_range(0, 2))
      0: send_item(CMD_KEY, '0, KEY_LEFT);
      1: send_item(CMD_KEY, '0, KEY_RIGHT);
      default: send_item(CMD_KEY, '0, KEY_UP);
    endcase
    repeat (3) send_item(CMD_KEY, '0, KEY_RIGHT);
    send_item(CMD_KEY, '0, KEY_UP);
    repeat (3) send_item(CMD_KEY, '0, KEY_LEFT);
    send_item(CMD_KEY, '0, KEY_UP);
    send_item(CMD_KEY, '0, KEY_DOWN);
    send_item(CMD_KEY, '0, KEY_DOWN);
    send_item(CMD_KEY, '0, KEY_STAR);
  endtask

  task automatic test_band_edges();
    // With setpoint 494 and deadband 5 the lower bound equals adc 100 exactly.
    pin_setpoint(494);
    send_item(CMD_SAMPLE, 10'd100, '0);
    send_item(CMD_SAMPLE, 10'd99, '0);
    pin_setpoint(484);
    send_item(CMD_SAMPLE, 10'd100, '0);
    send_item(CMD_SAMPLE, 10'd101, '0);
    send_item(CMD_SAMPLE, 10'd1023, '0);
    cfg_write(REG_DEADBAND, 100);
    pin_setpoint(50);
    send_item(CMD_SAMPLE, 10'd0, '0);
  endtask

  task automatic test_setpoint_clamp();
    set_config(5, 300, 200, 200);
    send_item(CMD_KEY, '0, KEY_UP);
    pin_setpoint(0);
    cfg_write(REG_MAX_SP, 1000);
    send_item(CMD_KEY, '0, KEY_DOWN);
    pin_setpoint(1000);
    cfg_write(REG_MIN_SP, 0);
    send_item(CMD_KEY, '0, KEY_UP);
  endtask

  task automatic test_pwm_duty();
    pin_setpoint(500);
    send_item(CMD_SAMPLE, '0, '0);
    cfg_write(REG_DUTY, 0);
    send_item(CMD_TICK, '0, '0);
    cfg_write(REG_DUTY, 255);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_SAMPLE, 10'd1023, '0);
  endtask

  task automatic send_random_item();
    cmd_e_t cmd;
    logic [ADC_W-1:0] adc;
    logic [KEY_W-1:0] key;
    int pick;
    int near_adc;
    pick = $urandom_range(0, 99);
    if (pick < 45) cmd = CMD_TICK;
    else if (pick < 75) cmd = CMD_SAMPLE;
    else if (pick < 97) cmd = CMD_KEY;
    else cmd = CMD_NONE;
    if ($urandom_range(0, 1) == 0) begin
      near_adc = (int'(sp_tenths) + ($urandom_range(0, 1) ? 1 : -1) * int'(band_cfg))
                 * int'(TENTHS_SCALE) / int'(ADC_SCALE) + int'($urandom_range(0, 2)) - 1;
      if (near_adc < 0) near_adc = 0;
      if (near_adc > 1023) near_adc = 1023;
      adc = near_adc[ADC_W-1:0];
    end else begin
      adc = ADC_W'($urandom_range(0, 1023));
    end
    case ($urandom_range(0, 9))
      0, 1, 2: key = KEY_UP;
      3, 4: key = KEY_DOWN;
      5: key = KEY_LEFT;
      6: key = KEY_RIGHT;
      default: key = KEY_W'($urandom_range(0, 11));
    endcase
    send_item(cmd, adc, key);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: set_config(0, 0, 1000, 255);
        1: set_config(100, 0, 1000, 0);
        2: set_config(int'(DEADBAND_RESET), int'(MIN_SP_RESET), int'(MAX_SP_RESET),
                      int'(DUTY_RESET));
        3: set_config($urandom_range(0, 100), 600, 400, 128);
        4: set_config(100, 0, 60, $urandom_range(0, 255));
        5: set_config(1, 1000, 1000, 1);
        default: begin
          set_config($urandom_range(0, 100), $urandom_range(0, 500),
                     $urandom_range(300, 1000), $urandom_range(0, 255));
        end
      endcase
      repeat (PHASE_ITEMS) send_random_item();
    end
    check_registers();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_menu_pages();
    test_band_edges();
    test_setpoint_clamp();
    test_pwm_duty();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/dtp_pkg.sv
hdl/dtp_cfg.sv
hdl/dtp_core.sv
hdl/deadband_thermostat_pwm.sv
tb/tb.sv
